FILE: rtl/time_window_coincidence_pairer_macros.svh
// Assertion macros of the pairer checker
`ifndef TIME_WINDOW_COINCIDENCE_PAIRER_MACROS_SVH
`define TIME_WINDOW_COINCIDENCE_PAIRER_MACROS_SVH

// check a property on every rising edge outside reset
`define TWCP_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// check that an antecedent is followed in the next cycle by a consequent
`define TWCP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/twcp_pkg.sv
// Shared types and constants of the coincidence pairer
`timescale 1ns / 1ps

package twcp_pkg;

    localparam int PHOTON_TIME_W = 48;
    localparam int REGION_W      = 3;
    localparam int TAG_W         = 16;
    localparam int WINDOW_W      = 20;
    localparam int PAIRS_W       = 64;
    localparam int CFG_INDEX_W   = 4;
    localparam int CFG_DATA_W    = 64;

    localparam logic [CFG_INDEX_W-1:0] CFG_COINCIDENCE_WINDOW   = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] CFG_ALLOWED_REGION_PAIRS = CFG_INDEX_W'(1);

    typedef struct packed {
        logic [PHOTON_TIME_W-1:0] first_time;
        logic [REGION_W-1:0]      first_region;
        logic [TAG_W-1:0]         first_tag;
        logic [PHOTON_TIME_W-1:0] second_time;
        logic [REGION_W-1:0]      second_region;
        logic [TAG_W-1:0]         second_tag;
        logic                     last_pair;
    } pair_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXPIRE,
        ST_SCAN,
        ST_FLUSH,
        ST_STORE
    } twcp_state_t;

endpackage

FILE: rtl/twcp_window_store.sv
// Circular photon store: one write port, one registered read port
`timescale 1ns / 1ps

module twcp_window_store #(
    parameter int DEPTH     = 16,
    parameter int TIME_BITS = 48,
    localparam int IDX_W    = $clog2(DEPTH)
) (
    input  logic                          clk,
    input  logic                          wr_en,
    input  logic [IDX_W-1:0]              wr_addr,
    input  logic [TIME_BITS-1:0]          wr_time,
    input  logic [twcp_pkg::REGION_W-1:0] wr_region,
    input  logic [twcp_pkg::TAG_W-1:0]    wr_tag,
    input  logic [IDX_W-1:0]              rd_addr,
    output logic [TIME_BITS-1:0]          rd_time,
    output logic [twcp_pkg::REGION_W-1:0] rd_region,
    output logic [twcp_pkg::TAG_W-1:0]    rd_tag
);
    import twcp_pkg::*;

    logic [TIME_BITS-1:0] time_mem   [DEPTH];
    logic [REGION_W-1:0]  region_mem [DEPTH];
    logic [TAG_W-1:0]     tag_mem    [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            time_mem[wr_addr]   <= wr_time;
            region_mem[wr_addr] <= wr_region;
            tag_mem[wr_addr]    <= wr_tag;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_time   <= time_mem[rd_addr];
        rd_region <= region_mem[rd_addr];
        rd_tag    <= tag_mem[rd_addr];
    end

endmodule

FILE: rtl/time_window_coincidence_pairer.sv
// Top level of the time-window coincidence pairer
// Per word: accept it, drop each expired entry from the oldest end, scan each remaining
// entry against the new word, flush the held pair and store the word; an empty store
// skips straight to the store step. The pair output can hold back the scan and flush.
// A single time comparator and a single store read port serve every step.
// Reset clears fill, head and sequencer, zeroes the window and allows all region pairs; store contents stay undefined.
`timescale 1ns / 1ps

module time_window_coincidence_pairer #(
    parameter int WINDOW_DEPTH = 16,
    parameter int REGION_COUNT = 8,
    parameter int TIME_BITS    = 48
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_write,
    input  logic [twcp_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [twcp_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                               photon_valid,
    output logic                               photon_ready,
    input  logic [twcp_pkg::PHOTON_TIME_W-1:0] photon_time,
    input  logic [twcp_pkg::REGION_W-1:0]      photon_region,
    input  logic [twcp_pkg::TAG_W-1:0]         photon_tag,
    output logic                               pair_valid,
    input  logic                               pair_ready,
    output logic [twcp_pkg::PHOTON_TIME_W-1:0] first_time,
    output logic [twcp_pkg::REGION_W-1:0]      first_region,
    output logic [twcp_pkg::TAG_W-1:0]         first_tag,
    output logic [twcp_pkg::PHOTON_TIME_W-1:0] second_time,
    output logic [twcp_pkg::REGION_W-1:0]      second_region,
    output logic [twcp_pkg::TAG_W-1:0]         second_tag,
    output logic                               last_pair
);
    import twcp_pkg::*;

    localparam int IDX_W  = $clog2(WINDOW_DEPTH);
    localparam int FILL_W = $clog2(WINDOW_DEPTH + 1);
    localparam int CMP_W  = (TIME_BITS > WINDOW_W) ? TIME_BITS : WINDOW_W;
    localparam logic [IDX_W-1:0]    LAST_IDX  = IDX_W'(WINDOW_DEPTH - 1);
    localparam logic [IDX_W:0]      DEPTH_SUM = (IDX_W + 1)'(WINDOW_DEPTH);
    localparam logic [FILL_W-1:0]   FULL_FILL = FILL_W'(WINDOW_DEPTH);
    localparam logic [REGION_W:0]   REG_LIMIT = (REGION_W + 1)'(REGION_COUNT);

    twcp_state_t           state_reg, state_next;
    logic [FILL_W-1:0]     fill_reg, fill_next;
    logic [IDX_W-1:0]      head_reg, head_next;
    logic [IDX_W-1:0]      ptr_reg, ptr_next;
    logic [FILL_W-1:0]     cnt_reg, cnt_next;
    logic                  pend_valid_reg, pend_valid_next;
    logic                  out_valid_reg, out_valid_next;
    pair_t                 pend_reg, pend_next;
    pair_t                 out_reg, out_next;
    logic [WINDOW_W-1:0]   win_reg, win_next;
    logic [PAIRS_W-1:0]    pairs_reg, pairs_next;
    logic [TIME_BITS-1:0]  t_reg;
    logic [REGION_W-1:0]   r_reg;
    logic [TAG_W-1:0]      g_reg;

    logic                  load_in;
    logic                  wr_en;
    logic [IDX_W-1:0]      wr_addr;
    logic [IDX_W-1:0]      rd_addr;
    logic [TIME_BITS-1:0]  rd_time;
    logic [REGION_W-1:0]   rd_region;
    logic [TAG_W-1:0]      rd_tag;

    logic [TIME_BITS:0]    diff_fwd;
    logic [TIME_BITS-1:0]  diff_bwd;
    logic [TIME_BITS-1:0]  diff_mag;
    logic                  time_ge;
    logic                  time_over;
    logic                  expire;
    logic                  region_ok;
    logic                  match;
    logic                  out_free;
    logic                  full;
    logic [IDX_W:0]        tail_sum;
    logic [IDX_W-1:0]      tail_idx;
    logic [IDX_W-1:0]      head_inc;
    logic [IDX_W-1:0]      ptr_inc;
    pair_t                 new_pair;

    twcp_window_store #(
        .DEPTH     (WINDOW_DEPTH),
        .TIME_BITS (TIME_BITS)
    ) u_store (
        .clk       (clk),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_time   (t_reg),
        .wr_region (r_reg),
        .wr_tag    (g_reg),
        .rd_addr   (rd_addr),
        .rd_time   (rd_time),
        .rd_region (rd_region),
        .rd_tag    (rd_tag)
    );

    // shared time comparator
    assign diff_fwd  = {1'b0, t_reg} - {1'b0, rd_time};
    assign diff_bwd  = rd_time - t_reg;
    assign time_ge   = ~diff_fwd[TIME_BITS];
    assign diff_mag  = time_ge ? diff_fwd[TIME_BITS-1:0] : diff_bwd;
    assign time_over = CMP_W'(diff_mag) > CMP_W'(win_reg);
    assign expire    = time_ge && time_over;

    assign region_ok = ({1'b0, rd_region} < REG_LIMIT) && ({1'b0, r_reg} < REG_LIMIT);
    assign match     = !time_over && region_ok && pairs_reg[{rd_region, r_reg}];
    assign out_free  = !out_valid_reg || pair_ready;

    assign full      = (fill_reg == FULL_FILL);
    assign tail_sum  = {1'b0, head_reg} + {1'b0, fill_reg[IDX_W-1:0]};
    assign tail_idx  = (tail_sum >= DEPTH_SUM) ? IDX_W'(tail_sum - DEPTH_SUM)
                                               : tail_sum[IDX_W-1:0];
    assign wr_addr   = full ? head_reg : tail_idx;
    assign head_inc  = (head_reg == LAST_IDX) ? '0 : head_reg + IDX_W'(1);
    assign ptr_inc   = (ptr_reg == LAST_IDX) ? '0 : ptr_reg + IDX_W'(1);

    always_comb
    begin
        if (r_reg >= rd_region)
        begin
            new_pair.first_time    = PHOTON_TIME_W'(t_reg);
            new_pair.first_region  = r_reg;
            new_pair.first_tag     = g_reg;
            new_pair.second_time   = PHOTON_TIME_W'(rd_time);
            new_pair.second_region = rd_region;
            new_pair.second_tag    = rd_tag;
        end
        else
        begin
            new_pair.first_time    = PHOTON_TIME_W'(rd_time);
            new_pair.first_region  = rd_region;
            new_pair.first_tag     = rd_tag;
            new_pair.second_time   = PHOTON_TIME_W'(t_reg);
            new_pair.second_region = r_reg;
            new_pair.second_tag    = g_reg;
        end
        new_pair.last_pair = 1'b0;
    end

    always_comb
    begin
        win_next   = win_reg;
        pairs_next = pairs_reg;
        if (cfg_write)
        begin
            priority case (cfg_index)
                CFG_COINCIDENCE_WINDOW:   win_next   = cfg_data[WINDOW_W-1:0];
                CFG_ALLOWED_REGION_PAIRS: pairs_next = cfg_data[PAIRS_W-1:0];
                default:                  win_next   = win_reg;
            endcase
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        fill_next       = fill_reg;
        head_next       = head_reg;
        ptr_next        = ptr_reg;
        cnt_next        = cnt_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        out_valid_next  = out_valid_reg && !pair_ready;
        out_next        = out_reg;
        rd_addr         = ptr_reg;
        wr_en           = 1'b0;
        load_in         = 1'b0;
        photon_ready    = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                photon_ready = 1'b1;
                rd_addr      = head_reg;
                if (photon_valid)
                begin
                    load_in    = 1'b1;
                    state_next = (fill_reg != '0) ? ST_EXPIRE : ST_STORE;
                end
            end
            ST_EXPIRE:
            begin
                rd_addr = head_reg;
                if (expire)
                begin
                    // drop the oldest word
                    head_next = head_inc;
                    fill_next = fill_reg - FILL_W'(1);
                    rd_addr   = head_inc;
                    if (fill_reg == FILL_W'(1))
                    begin
                        state_next = ST_FLUSH;
                    end
                end
                else
                begin
                    ptr_next   = head_reg;
                    cnt_next   = '0;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                rd_addr = ptr_reg;
                if (!(match && pend_valid_reg && !out_free))
                begin
                    if (match)
                    begin
                        if (pend_valid_reg)
                        begin
                            out_next       = pend_reg;
                            out_valid_next = 1'b1;
                        end
                        pend_next       = new_pair;
                        pend_valid_next = 1'b1;
                    end
                    ptr_next = ptr_inc;
                    rd_addr  = ptr_inc;
                    cnt_next = cnt_reg + FILL_W'(1);
                    if (cnt_reg + FILL_W'(1) == fill_reg)
                    begin
                        state_next = ST_FLUSH;
                    end
                end
            end
            ST_FLUSH:
            begin
                if (pend_valid_reg)
                begin
                    if (out_free)
                    begin
                        out_next           = pend_reg;
                        out_next.last_pair = 1'b1;
                        out_valid_next     = 1'b1;
                        pend_valid_next    = 1'b0;
                        state_next         = ST_STORE;
                    end
                end
                else
                begin
                    state_next = ST_STORE;
                end
            end
            ST_STORE:
            begin
                wr_en = 1'b1;
                if (full)
                begin
                    head_next = head_inc;
                end
                else
                begin
                    fill_next = fill_reg + FILL_W'(1);
                end
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            fill_reg       <= '0;
            head_reg       <= '0;
            ptr_reg        <= '0;
            cnt_reg        <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            win_reg        <= '0;
            pairs_reg      <= '1;
        end
        else
        begin
            state_reg      <= state_next;
            fill_reg       <= fill_next;
            head_reg       <= head_next;
            ptr_reg        <= ptr_next;
            cnt_reg        <= cnt_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
            win_reg        <= win_next;
            pairs_reg      <= pairs_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_reg <= pend_next;
        out_reg  <= out_next;
        if (load_in)
        begin
            t_reg <= TIME_BITS'(photon_time);
            r_reg <= photon_region;
            g_reg <= photon_tag;
        end
    end

    assign pair_valid    = out_valid_reg;
    assign first_time    = out_reg.first_time;
    assign first_region  = out_reg.first_region;
    assign first_tag     = out_reg.first_tag;
    assign second_time   = out_reg.second_time;
    assign second_region = out_reg.second_region;
    assign second_tag    = out_reg.second_tag;
    assign last_pair     = out_reg.last_pair;

endmodule

FILE: rtl/twcp_checker.sv
// Port-level checker of the coincidence pairer, bound to the top level
`timescale 1ns / 1ps
`include "time_window_coincidence_pairer_macros.svh"

module twcp_checker (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               photon_valid,
    input  logic                               photon_ready,
    input  logic                               pair_valid,
    input  logic                               pair_ready,
    input  logic [twcp_pkg::PHOTON_TIME_W-1:0] first_time,
    input  logic [twcp_pkg::REGION_W-1:0]      first_region,
    input  logic [twcp_pkg::TAG_W-1:0]         first_tag,
    input  logic [twcp_pkg::PHOTON_TIME_W-1:0] second_time,
    input  logic [twcp_pkg::REGION_W-1:0]      second_region,
    input  logic [twcp_pkg::TAG_W-1:0]         second_tag,
    input  logic                               last_pair
);
    import twcp_pkg::*;

    `TWCP_ASSERT_NEXT(a_pair_hold, pair_valid && !pair_ready, pair_valid && $stable({first_time, first_region, first_tag, second_time, second_region, second_tag, last_pair}), "stalled pair word changed")

    `TWCP_ASSERT_NEXT(a_busy_after_accept, photon_valid && photon_ready, !photon_ready, "photon ready again right after accept")

    `TWCP_ASSERT(a_region_order, !pair_valid || (first_region >= second_region), "pair regions out of order")

endmodule

bind time_window_coincidence_pairer twcp_checker u_twcp_checker (.*);

FILE: verif/time_window_coincidence_pairer_test.sv
// Self-checking testbench for the time-window coincidence pairer
`timescale 1ns / 1ps

module time_window_coincidence_pairer_test;
    import twcp_pkg::*;

    localparam int STORE_DEPTH  = 16;
    localparam int SETTLE_CYCLES = 40;
    localparam int HOLD_CYCLES  = 400;
    localparam int QUIET_LIMIT  = 3000;
    localparam int IDLE_PERCENT = 37;
    localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED_INDEX = CFG_INDEX_W'(15);
    localparam logic [PHOTON_TIME_W-1:0] DIRECTED_BASE = 48'hFFFF_FFE0_0000;

    typedef struct packed {
        logic [PHOTON_TIME_W-1:0] stamp;
        logic [REGION_W-1:0]      region;
        logic [TAG_W-1:0]         tag;
    } photon_word_t;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     cfg_write = 1'b0;
    logic [CFG_INDEX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]    cfg_data = '0;
    logic                     photon_valid = 1'b0;
    logic                     photon_ready;
    logic [PHOTON_TIME_W-1:0] photon_time = '0;
    logic [REGION_W-1:0]      photon_region = '0;
    logic [TAG_W-1:0]         photon_tag = '0;
    logic                     pair_valid;
    logic                     pair_ready = 1'b0;
    logic [PHOTON_TIME_W-1:0] first_time;
    logic [REGION_W-1:0]      first_region;
    logic [TAG_W-1:0]         first_tag;
    logic [PHOTON_TIME_W-1:0] second_time;
    logic [REGION_W-1:0]      second_region;
    logic [TAG_W-1:0]         second_tag;
    logic                     last_pair;

    photon_word_t pending_photons[$];
    pair_t        expected_pairs[$];
    photon_word_t next_word;
    pair_t        got_pair;
    pair_t        want_pair;

    int unsigned photons_queued = 0;
    int unsigned photons_taken = 0;
    int unsigned mismatches = 0;
    int unsigned quiet_cycles = 0;
    int unsigned hold_left = 0;
    bit          hold_request = 1'b0;
    bit          steady = 1'b0;
    bit          photon_took = 1'b0;
    logic [PHOTON_TIME_W-1:0] stamp_cursor = '0;

    // predictor copy of the photon store and the registers
    logic [PHOTON_TIME_W-1:0] store_time[STORE_DEPTH];
    logic [REGION_W-1:0]      store_region[STORE_DEPTH];
    logic [TAG_W-1:0]         store_tag[STORE_DEPTH];
    int unsigned              store_fill = 0;
    logic [3:0]               store_head = '0;
    logic [WINDOW_W-1:0]      window_ticks = '0;
    logic [PAIRS_W-1:0]       region_pair_mask = '1;

    time_window_coincidence_pairer DUT (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_write(cfg_write),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .photon_valid(photon_valid),
        .photon_ready(photon_ready),
        .photon_time(photon_time),
        .photon_region(photon_region),
        .photon_tag(photon_tag),
        .pair_valid(pair_valid),
        .pair_ready(pair_ready),
        .first_time(first_time),
        .first_region(first_region),
        .first_tag(first_tag),
        .second_time(second_time),
        .second_region(second_region),
        .second_tag(second_tag),
        .last_pair(last_pair)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    task automatic predict_pairs(input logic [PHOTON_TIME_W-1:0] t,
                                 input logic [REGION_W-1:0] r,
                                 input logic [TAG_W-1:0] g);
        logic [PHOTON_TIME_W-1:0] st;
        logic [PHOTON_TIME_W-1:0] gap;
        logic [3:0]               idx;
        logic [5:0]               pair_bit;
        pair_t                    batch[$];
        pair_t                    p;
        int unsigned              k;
        // drop expired entries from the oldest end
        while (store_fill > 0)
        begin
            st = store_time[store_head];
            if (t >= st && t - st > PHOTON_TIME_W'(window_ticks))
            begin
                store_head = store_head + 4'd1;
                store_fill--;
            end
            else
                break;
        end
        for (k = 0; k < store_fill; k++)
        begin
            idx = store_head + 4'(k);
            st = store_time[idx];
            gap = (t >= st) ? t - st : st - t;
            if (gap > PHOTON_TIME_W'(window_ticks))
                continue;
            pair_bit = {store_region[idx], r};
            if (!region_pair_mask[pair_bit])
                continue;
            if (r >= store_region[idx])
                p = {t, r, g, st, store_region[idx], store_tag[idx], 1'b0};
            else
                p = {st, store_region[idx], store_tag[idx], t, r, g, 1'b0};
            batch.push_back(p);
        end
        if (batch.size() > 0)
            batch[batch.size() - 1].last_pair = 1'b1;
        foreach (batch[i])
            expected_pairs.push_back(batch[i]);
        if (store_fill >= STORE_DEPTH)
        begin
            store_head = store_head + 4'd1;
            store_fill = STORE_DEPTH - 1;
        end
        idx = store_head + 4'(store_fill);
        store_time[idx] = t;
        store_region[idx] = r;
        store_tag[idx] = g;
        store_fill++;
    endtask

    // photon driver
    always @(negedge clk)
    begin
        if (!rst_n)
            photon_valid <= 1'b0;
        else if (!photon_valid || photon_took)
        begin
            if (pending_photons.size() > 0
                && (steady || $urandom_range(99) >= IDLE_PERCENT))
            begin
                next_word = pending_photons.pop_front();
                photon_valid <= 1'b1;
                photon_time <= next_word.stamp;
                photon_region <= next_word.region;
                photon_tag <= next_word.tag;
            end
            else
                photon_valid <= 1'b0;
        end
    end

    // pair receiver
    always @(negedge clk)
    begin
        if (hold_request)
        begin
            hold_left = HOLD_CYCLES;
            hold_request = 1'b0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            pair_ready <= 1'b0;
        end
        else
            pair_ready <= steady || ($urandom_range(99) >= IDLE_PERCENT);
    end

    // monitor and checker
    always @(posedge clk)
    begin
        photon_took = rst_n && photon_valid && photon_ready;
        if (rst_n)
        begin
            if (cfg_write)
            begin
                if (cfg_index == CFG_COINCIDENCE_WINDOW)
                    window_ticks = cfg_data[WINDOW_W-1:0];
                else if (cfg_index == CFG_ALLOWED_REGION_PAIRS)
                    region_pair_mask = cfg_data;
            end
            if (photon_took)
            begin
                predict_pairs(photon_time, photon_region, photon_tag);
                photons_taken++;
            end
            if (pair_valid && pair_ready)
            begin
                got_pair = {first_time, first_region, first_tag,
                            second_time, second_region, second_tag, last_pair};
                if (expected_pairs.size() == 0)
                begin
                    $display("%0t: unexpected pair, expected none, actual %h/%0d/%h %h/%0d/%h last %b",
                             $time, first_time, first_region, first_tag,
                             second_time, second_region, second_tag, last_pair);
                    mismatches++;
                end
                else
                begin
                    want_pair = expected_pairs.pop_front();
                    if (got_pair !== want_pair)
                    begin
                        $display("%0t: pair mismatch, expected %h/%0d/%h %h/%0d/%h last %b",
                                 $time, want_pair.first_time, want_pair.first_region,
                                 want_pair.first_tag, want_pair.second_time,
                                 want_pair.second_region, want_pair.second_tag,
                                 want_pair.last_pair);
                        $display("%0t:                actual %h/%0d/%h %h/%0d/%h last %b",
                                 $time, first_time, first_region, first_tag,
                                 second_time, second_region, second_tag, last_pair);
                        mismatches++;
                    end
                end
            end
        end
    end

    // watchdog on handshake activity
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((photon_valid && photon_ready) || (pair_valid && pair_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    task automatic offer_photon(input logic [PHOTON_TIME_W-1:0] t,
                                input logic [REGION_W-1:0] r,
                                input logic [TAG_W-1:0] g);
        pending_photons.push_back({t, r, g});
        photons_queued++;
    endtask

    task automatic write_register(input logic [CFG_INDEX_W-1:0] index,
                                  input logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= index;
        cfg_data <= value;
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    // hold until every word is taken and every pair has come, then settle
    task automatic drain_block;
        do
            @(negedge clk);
        while (photons_taken != photons_queued || expected_pairs.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic offer_random_burst(input int unsigned count, input int unsigned spread);
        int unsigned pick;
        int unsigned n;
        stamp_cursor = {16'($urandom), 32'($urandom)};
        for (n = 0; n < count; n++)
        begin
            pick = $urandom_range(99);
            if (pick < 15)
                stamp_cursor = stamp_cursor;
            else if (pick < 25)
                stamp_cursor = stamp_cursor + spread * 4 + $urandom_range(spread);
            else if (pick < 30)
                stamp_cursor = stamp_cursor - $urandom_range(spread);
            else
                stamp_cursor = stamp_cursor + $urandom_range(spread);
            offer_photon(stamp_cursor, REGION_W'($urandom_range(7)), TAG_W'($urandom));
        end
    endtask

    initial
    begin
        int unsigned i;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset settings: zero window, all region pairs allowed
        offer_photon('0, 3'd7, 16'hFFFF);
        offer_photon('0, 3'd0, 16'h0000);
        offer_photon('0, 3'd7, 16'h1234);
        offer_photon(48'd1, 3'd3, 16'h00AA);
        drain_block();

        write_register(CFG_UNUSED_INDEX, '0);
        write_register(CFG_COINCIDENCE_WINDOW, '1);
        // fill the store, evict, hit the window edge, step back in time
        for (i = 0; i < STORE_DEPTH; i++)
            offer_photon(DIRECTED_BASE + i, REGION_W'(i), TAG_W'(16'hA500 + i));
        offer_photon(DIRECTED_BASE + 48'hF_FFFF, 3'd7, 16'h5A5A);
        offer_photon(DIRECTED_BASE + 48'h10_0001, 3'd4, 16'hC3C3);
        offer_photon(DIRECTED_BASE + 48'd5, 3'd2, 16'h0F0F);
        offer_photon('1, 3'd6, 16'hF0F0);
        drain_block();

        write_register(CFG_COINCIDENCE_WINDOW, 64'd200);
        write_register(CFG_ALLOWED_REGION_PAIRS, {$urandom, $urandom});
        offer_random_burst(40, 80);
        drain_block();

        write_register(CFG_COINCIDENCE_WINDOW, '0);
        write_register(CFG_ALLOWED_REGION_PAIRS, '1);
        offer_random_burst(30, 2);
        drain_block();

        write_register(CFG_COINCIDENCE_WINDOW, 64'hF_FFFF);
        write_register(CFG_ALLOWED_REGION_PAIRS, '0);
        offer_random_burst(10, 100);
        drain_block();

        steady = 1'b1;
        write_register(CFG_COINCIDENCE_WINDOW, 64'd5000);
        write_register(CFG_ALLOWED_REGION_PAIRS, {$urandom, $urandom});
        offer_random_burst(40, 1500);
        drain_block();
        steady = 1'b0;

        // stall the receiver so the block backs up onto its input
        write_register(CFG_COINCIDENCE_WINDOW, 64'hF_FFFF);
        write_register(CFG_ALLOWED_REGION_PAIRS, '1);
        @(posedge clk);
        hold_request = 1'b1;
        offer_random_burst(40, 50);
        drain_block();

        write_register(CFG_COINCIDENCE_WINDOW, 64'd1000);
        write_register(CFG_ALLOWED_REGION_PAIRS, {$urandom, $urandom});
        offer_random_burst(40, 400);
        drain_block();

        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule
